@@ src/l2lsf_pkg.sv @@
// Shared types and constants for the learning switch forwarding block.
// No dependencies; imported by the table memory and the top level.
`timescale 1ns / 1ps
`default_nettype none

package l2lsf_pkg;

   localparam int MAC_W       = 48;
   localparam int NODE_W      = 2;
   localparam int EGRESS_W    = 4;
   localparam int LINK_W      = 16;
   localparam int LINK_IDX_W  = 4;
   localparam int GROUP_BIT   = 40;

   localparam logic [MAC_W-1:0]  BCAST_MAC  = {MAC_W{1'b1}};
   localparam logic [LINK_W-1:0] LINK_RESET = 16'h7BDE;

   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [NODE_W-1:0] node;
   } entry_type;

endpackage

`default_nettype wire

@@ src/l2lsf_table.sv @@
// Address table storage: one write port, one registered read port.
// Depends on l2lsf_pkg for the entry layout.
`timescale 1ns / 1ps
`default_nettype none

module l2lsf_table #(
   parameter int ENTRIES = 64,
   parameter int AW      = 6
) (
   input  wire                     clock,
   input  wire                     rd_en,
   input  wire  [AW-1:0]           rd_addr,
   output l2lsf_pkg::entry_type    rd_data,
   input  wire                     wr_en,
   input  wire  [AW-1:0]           wr_addr,
   input  l2lsf_pkg::entry_type    wr_data
);
   import l2lsf_pkg::*;

   entry_type mem_ff [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/l2_learning_switch_forward.sv @@
// Top level of the learning switch forwarding block: control, scan and decision.
// Depends on l2lsf_pkg and l2lsf_table.
`timescale 1ns / 1ps
`default_nettype none

// A frame header is taken when start is high and busy is low. The block then
// walks the learned addresses through the single read port of the table, one
// entry a cycle, matching source and destination together, and writes the
// learned source back in a final cycle. Busy stays high through the scan and
// the finishing state, so no new header is taken until it drops; the result
// appears in the first cycle with busy low, on rsp_valid for exactly one cycle.
// The receiver cannot stall: a result not taken in that cycle is lost. Learned
// entries fill the table from the bottom and are never removed, so a fill count
// marks which entries hold addresses and no clearing pass is needed after reset.
// link_mask is written through the csr_ channel, which is always ready; write it
// only while the block is idle.
module l2_learning_switch_forward #(
   parameter int NODES         = 4,
   parameter int TABLE_ENTRIES = 64
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire  [l2lsf_pkg::NODE_W-1:0]        req_ingress_node,
   input  wire  [l2lsf_pkg::MAC_W-1:0]         req_src_mac,
   input  wire  [l2lsf_pkg::MAC_W-1:0]         req_dst_mac,
   output logic                                rsp_valid,
   output logic [l2lsf_pkg::EGRESS_W-1:0]      rsp_egress_mask,
   output logic                                rsp_flooded,
   output logic                                rsp_learn_failed,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [l2lsf_pkg::LINK_W-1:0]        csr_data
);
   import l2lsf_pkg::*;

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   function automatic logic link_ok(input logic [LINK_W-1:0] mask,
                                    input logic [NODE_W-1:0] from,
                                    input int to);
      int lpos;
      lpos = int'(from) * NODES + to;
      return (int'(from) < NODES) && (to < NODES) && (lpos < LINK_W) &&
             mask[lpos[LINK_IDX_W-1:0]];
   endfunction

   logic [1:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         scan_ff, scan_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [AW-1:0]         rd_idx_ff, rd_idx_in;
   logic [LINK_W-1:0]     link_mask_ff;

   logic [NODE_W-1:0]     ingress_ff;
   logic [MAC_W-1:0]      src_ff, dst_ff;

   logic                  src_found_ff, src_found_in;
   logic [AW-1:0]         src_idx_ff, src_idx_in;
   logic                  dst_found_ff, dst_found_in;
   logic [NODE_W-1:0]     dst_node_ff, dst_node_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EGRESS_W-1:0]   egress_ff, egress_in;
   logic                  flooded_ff, flooded_in;
   logic                  failed_ff, failed_in;

   logic                  accept;
   logic                  rd_en;
   entry_type             rd_data;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   entry_type             wr_data;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   l2lsf_table #(
      .ENTRIES (TABLE_ENTRIES),
      .AW      (AW)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_comb begin
      logic                learn;
      logic [EGRESS_W-1:0] flood_mask;
      logic [NODE_W-1:0]   target;
      logic                known;
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      rd_en        = 1'b0;
      rd_vld_in    = 1'b0;
      rd_idx_in    = scan_ff[AW-1:0];
      src_found_in = src_found_ff;
      src_idx_in   = src_idx_ff;
      dst_found_in = dst_found_ff;
      dst_node_in  = dst_node_ff;
      rsp_valid_in = 1'b0;
      egress_in    = egress_ff;
      flooded_in   = flooded_ff;
      failed_in    = failed_ff;
      wr_en        = 1'b0;
      wr_addr      = src_idx_ff;
      wr_data      = '{mac: src_ff, node: ingress_ff};
      learn        = 1'b0;
      target       = dst_node_ff;
      known        = 1'b0;

      for (int i = 0; i < EGRESS_W; i++) begin
         flood_mask[i] = (i != int'(ingress_ff)) && link_ok(link_mask_ff, ingress_ff, i);
      end

      // fold in the entry read in the previous cycle
      if (rd_vld_ff) begin
         if (rd_data.mac == src_ff) begin
            src_found_in = 1'b1;
            src_idx_in   = rd_idx_ff;
         end
         if (rd_data.mac == dst_ff) begin
            dst_found_in = 1'b1;
            dst_node_in  = rd_data.node;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in     = ST_SCAN;
               scan_in      = '0;
               src_found_in = 1'b0;
               dst_found_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (scan_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               scan_in   = scan_ff + CW'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in  = ST_IDLE;
            failed_in = 1'b0;
            if (src_ff != BCAST_MAC) begin
               if (src_found_ff) begin
                  wr_en = 1'b1;
                  learn = 1'b1;
               end else if (count_ff < CW'(TABLE_ENTRIES)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  count_in = count_ff + CW'(1);
                  learn    = 1'b1;
               end else begin
                  failed_in = 1'b1;
               end
            end
            // a destination equal to the source just learned sits on the ingress node
            if (learn && (dst_ff == src_ff)) begin
               known  = 1'b1;
               target = ingress_ff;
            end else if (dst_found_ff) begin
               known  = 1'b1;
               target = dst_node_ff;
            end
            rsp_valid_in = 1'b1;
            if (dst_ff[GROUP_BIT] || !known) begin
               egress_in  = flood_mask;
               flooded_in = 1'b1;
            end else begin
               flooded_in = 1'b0;
               egress_in  = '0;
               if ((target != ingress_ff) && link_ok(link_mask_ff, ingress_ff, int'(target))) begin
                  egress_in = EGRESS_W'(1) << target;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         link_mask_ff <= LINK_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            link_mask_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      rd_idx_ff    <= rd_idx_in;
      src_found_ff <= src_found_in;
      src_idx_ff   <= src_idx_in;
      dst_found_ff <= dst_found_in;
      dst_node_ff  <= dst_node_in;
      egress_ff    <= egress_in;
      flooded_ff   <= flooded_in;
      failed_ff    <= failed_in;
      if (accept) begin
         ingress_ff <= req_ingress_node;
         src_ff     <= req_src_mac;
         dst_ff     <= req_dst_mac;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_egress_mask  = egress_ff;
   assign rsp_flooded      = flooded_ff;
   assign rsp_learn_failed = failed_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_ENTRIES))
      else $error("fill count beyond table size");

   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_DONE))
      else $error("result beat without a finishing cycle");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN))
      else $error("accepted header did not start a scan");

   a_fail_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && failed_ff) |-> (count_ff == CW'(TABLE_ENTRIES)))
      else $error("learn failure with free entries left");

   a_write_no_read: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!rd_en && !rd_vld_ff))
      else $error("table write overlaps a scan read");
`endif

endmodule

`default_nettype wire

@@ sim/l2_learning_switch_forward_test.sv @@
// Self-checking testbench for the learning switch forwarding block.
// Drives frame headers and link masks, predicts decisions in a shadow table
// or takes pinned ones, and compares each result beat. Needs l2lsf_pkg.
`timescale 1ns / 1ps

module l2_learning_switch_forward_test;

   import l2lsf_pkg::*;

   localparam int NODES         = 4;
   localparam int TABLE_ENTRIES = 64;
   localparam int POOL_SIZE     = 96;
   localparam int PHASE_ITEMS   = 250;

   typedef struct packed {
      logic [EGRESS_W-1:0] egress_mask;
      logic                flooded;
      logic                learn_failed;
   } fwd_result_t;

   typedef struct {
      logic              set_link;
      logic [LINK_W-1:0] link;
      logic [NODE_W-1:0] node;
      logic [MAC_W-1:0]  src;
      logic [MAC_W-1:0]  dst;
      logic              pinned;
      fwd_result_t       want;
   } header_row_t;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [NODE_W-1:0]    req_ingress_node;
   logic [MAC_W-1:0]     req_src_mac;
   logic [MAC_W-1:0]     req_dst_mac;
   logic                 rsp_valid;
   logic [EGRESS_W-1:0]  rsp_egress_mask;
   logic                 rsp_flooded;
   logic                 rsp_learn_failed;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [LINK_W-1:0]    csr_data;

   // shadow of the block's state
   logic                 station_valid [TABLE_ENTRIES];
   logic [MAC_W-1:0]     station_mac   [TABLE_ENTRIES];
   logic [NODE_W-1:0]    station_node  [TABLE_ENTRIES];
   logic [LINK_W-1:0]    link_shadow;

   fwd_result_t          decision_q [$];
   fwd_result_t          pin_result;
   logic                 pin_valid;
   int                   fault_count;
   header_row_t          header_rows [$];
   logic [MAC_W-1:0]     station_pool [POOL_SIZE];

   l2_learning_switch_forward #(
      .NODES         (NODES),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_ingress_node (req_ingress_node),
      .req_src_mac      (req_src_mac),
      .req_dst_mac      (req_dst_mac),
      .rsp_valid        (rsp_valid),
      .rsp_egress_mask  (rsp_egress_mask),
      .rsp_flooded      (rsp_flooded),
      .rsp_learn_failed (rsp_learn_failed),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic link_up(input int from, input int to);
      int bit_idx;
      if (from >= NODES || to >= NODES) return 1'b0;
      bit_idx = from * NODES + to;
      if (bit_idx >= LINK_W) return 1'b0;
      return link_shadow[bit_idx];
   endfunction

   function automatic logic [EGRESS_W-1:0] flood_links(input int from);
      logic [EGRESS_W-1:0] m;
      m = '0;
      for (int i = 0; i < NODES && i < EGRESS_W; i++)
         if (i != from && link_up(from, i)) m[i] = 1'b1;
      return m;
   endfunction

   function automatic int find_station(input logic [MAC_W-1:0] mac);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (station_valid[i] && station_mac[i] == mac) return i;
      return -1;
   endfunction

   // learn the source first, then look up the destination
   function automatic fwd_result_t forward_header(input logic [NODE_W-1:0] node,
                                                  input logic [MAC_W-1:0] src,
                                                  input logic [MAC_W-1:0] dst);
      fwd_result_t r;
      int          idx;
      int          target;
      r = '0;
      if (src != BCAST_MAC) begin
         idx = find_station(src);
         if (idx < 0)
            for (int i = 0; i < TABLE_ENTRIES && idx < 0; i++)
               if (!station_valid[i]) idx = i;
         if (idx < 0) begin
            r.learn_failed = 1'b1;
         end else begin
            station_valid[idx] = 1'b1;
            station_mac[idx]   = src;
            station_node[idx]  = node;
         end
      end
      if (dst[GROUP_BIT]) begin
         r.egress_mask = flood_links(node);
         r.flooded     = 1'b1;
      end else begin
         idx = find_station(dst);
         if (idx >= 0) begin
            target = station_node[idx];
            if (target != node && link_up(node, target) && target < EGRESS_W)
               r.egress_mask[target] = 1'b1;
         end else begin
            r.egress_mask = flood_links(node);
            r.flooded     = 1'b1;
         end
      end
      return r;
   endfunction

   task automatic report_fault(input string what, input fwd_result_t want,
                               input fwd_result_t got);
      fault_count++;
      if (fault_count <= 10)
         $display({"%0t %s: expected egress %b flooded %b failed %b,",
                   " got egress %b flooded %b failed %b"},
                  $realtime, what, want.egress_mask, want.flooded, want.learn_failed,
                  got.egress_mask, got.flooded, got.learn_failed);
   endtask

   // check result beats first, then record any header taken on this edge
   always @(posedge clock) begin : monitor
      fwd_result_t got;
      fwd_result_t want;
      if (!reset) begin
         if (rsp_valid) begin
            got = {rsp_egress_mask, rsp_flooded, rsp_learn_failed};
            if (decision_q.size() == 0) begin
               report_fault("unexpected result", '0, got);
            end else begin
               want = decision_q.pop_front();
               if (got.egress_mask !== want.egress_mask || got.flooded !== want.flooded ||
                   got.learn_failed !== want.learn_failed)
                  report_fault("mismatch", want, got);
            end
         end
         if (csr_valid && csr_ready) link_shadow = csr_data;
         if (start && !busy) begin
            want = forward_header(req_ingress_node, req_src_mac, req_dst_mac);
            if (pin_valid) want = pin_result;
            decision_q.insert(decision_q.size(), want);
         end
      end
   end

   task automatic send_header(input logic [NODE_W-1:0] node, input logic [MAC_W-1:0] src,
                              input logic [MAC_W-1:0] dst, input logic pin,
                              input fwd_result_t want);
      @(negedge clock);
      start            = 1'b1;
      req_ingress_node = node;
      req_src_mac      = src;
      req_dst_mac      = dst;
      pin_valid        = pin;
      pin_result       = want;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // drain all outstanding decisions before touching the link mask
   task automatic wait_idle();
      hold_off(1);
      while (decision_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_link(input logic [LINK_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic put_row(input logic set_link, input logic [LINK_W-1:0] link,
                          input logic [NODE_W-1:0] node, input logic [MAC_W-1:0] src,
                          input logic [MAC_W-1:0] dst, input logic pinned,
                          input logic [EGRESS_W-1:0] egress, input logic flooded,
                          input logic failed);
      header_row_t row;
      row.set_link = set_link;
      row.link     = link;
      row.node     = node;
      row.src      = src;
      row.dst      = dst;
      row.pinned   = pinned;
      row.want     = {egress, flooded, failed};
      header_rows.insert(header_rows.size(), row);
   endtask

   function automatic logic [MAC_W-1:0] random_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   initial begin : stimulus
      logic [LINK_W-1:0] phase_link;
      logic [MAC_W-1:0]  src;
      logic [MAC_W-1:0]  dst;
      int                pool_span;
      int                burst_left;
      int                pick;
      int                gap;

      reset            = 1'b1;
      start            = 1'b0;
      req_ingress_node = '0;
      req_src_mac      = '0;
      req_dst_mac      = '0;
      csr_valid        = 1'b0;
      csr_data         = '0;
      pin_valid        = 1'b0;
      pin_result       = '0;
      fault_count      = 0;
      link_shadow      = LINK_RESET;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         station_valid[i] = 1'b0;
         station_mac[i]   = '0;
         station_node[i]  = '0;
      end
      for (int i = 0; i < POOL_SIZE; i++) begin
         station_pool[i] = random_mac();
         // most stations are plain unicast; a few carry the group bit
         if ($urandom_range(0, 7) != 0) station_pool[i][GROUP_BIT] = 1'b0;
      end

      // reset mask is a full mesh: floods go to the other three nodes
      put_row(0, 0, 0, 48'h020000000001, BCAST_MAC, 1, 4'b1110, 1, 0);
      put_row(0, 0, 1, 48'h020000000002, 48'h020000000001, 0, 0, 0, 0);
      put_row(0, 0, 2, 48'h020000000003, 48'h02000000DEAD, 1, 4'b1011, 1, 0);
      put_row(0, 0, 3, BCAST_MAC, 48'h020000000001, 0, 0, 0, 0);
      put_row(0, 0, 3, BCAST_MAC, BCAST_MAC, 1, 4'b0111, 1, 0);
      // destination equal to source is local
      put_row(0, 0, 0, 48'h020000000001, 48'h020000000001, 1, 4'b0000, 0, 0);
      // station moves to another node
      put_row(0, 0, 2, 48'h020000000001, 48'h020000000002, 0, 0, 0, 0);
      put_row(0, 0, 1, 48'h000000000000, 48'h020000000001, 0, 0, 0, 0);
      put_row(0, 0, 3, 48'h01005E000001, 48'h01005E0000FB, 1, 4'b0111, 1, 0);
      put_row(0, 0, 0, 48'h020000000005, 48'h010000000000, 1, 4'b1110, 1, 0);
      put_row(0, 0, 2, 48'h7FFFFFFFFFFF, 48'hFFFFFFFFFFFE, 1, 4'b1011, 1, 0);
      put_row(0, 0, 0, 48'hFEFFFFFFFFFF, 48'h7FFFFFFFFFFF, 0, 0, 0, 0);
      put_row(0, 0, 3, 48'h800000000000, 48'hFEFFFFFFFFFF, 0, 0, 0, 0);
      put_row(0, 0, 1, 48'h000000000001, BCAST_MAC, 1, 4'b1101, 1, 0);
      // no links at all
      put_row(1, 16'h0000, 1, 48'h020000000006, 48'h02000000BEEF, 1, 4'b0000, 1, 0);
      put_row(0, 0, 0, 48'h020000000001, 48'h020000000002, 1, 4'b0000, 0, 0);
      // every link, self links included
      put_row(1, 16'hFFFF, 3, 48'h020000000007, BCAST_MAC, 1, 4'b0111, 1, 0);
      put_row(0, 0, 3, 48'h020000000008, 48'h020000000007, 0, 0, 0, 0);
      put_row(0, 0, 1, 48'h020000000008, 48'h020000000007, 0, 0, 0, 0);
      put_row(1, 16'h0001, 0, 48'h020000000001, BCAST_MAC, 1, 4'b0000, 1, 0);
      put_row(1, 16'h0010, 1, 48'h020000000002, 48'hFEFFFFFFFFFF, 0, 0, 0, 0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (header_rows[i]) begin
         if (header_rows[i].set_link) begin
            wait_idle();
            write_link(header_rows[i].link);
         end
         send_header(header_rows[i].node, header_rows[i].src, header_rows[i].dst,
                     header_rows[i].pinned, header_rows[i].want);
      end

      burst_left = 0;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: phase_link = LINK_RESET;
            1: phase_link = 16'hFFFF;
            2: phase_link = 16'h0000;
            default: phase_link = 16'($urandom);
         endcase
         wait_idle();
         write_link(phase_link);
         // later phases bring in enough new sources to fill the table
         pool_span = (phase < 3) ? 40 : POOL_SIZE;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 4)
                                                 : $urandom_range(0, 80);
               hold_off(gap);
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            if (pick < 6)
               src = BCAST_MAC;
            else if (pick < ((phase < 3) ? 6 : 26))
               src = random_mac();
            else
               src = station_pool[$urandom_range(0, pool_span - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
               dst = BCAST_MAC;
            end else if (pick < 24) begin
               dst = random_mac();
               dst[GROUP_BIT] = 1'b1;
            end else if (pick < 32) begin
               dst = random_mac();
            end else if (pick < 40) begin
               dst = src;
            end else begin
               dst = station_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            send_header(NODE_W'($urandom_range(0, 3)), src, dst, 1'b0, '0);
         end
      end

      hold_off(1);
      while (decision_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fault_count == 0 && decision_q.size() == 0) begin
         $display("[l2_learning_switch_forward] OK");
      end else begin
         $display("[l2_learning_switch_forward] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("[l2_learning_switch_forward] ERROR");
      $finish;
   end

endmodule

@@ l2_learning_switch_forward.f @@
src/l2lsf_pkg.sv
src/l2lsf_table.sv
src/l2_learning_switch_forward.sv
sim/l2_learning_switch_forward_test.sv
